/* rtl/gyro_hdu_pkg.sv */
// ----------------------------------------------------------------------------
// Gyro heading drift unwrap package
// Shared types and constants of the gyro heading block: register indexes,
// field widths and the turn constants in tenths of a degree.
// ----------------------------------------------------------------------------
package gyro_hdu_pkg;

   // Field widths
   localparam int SAMPLE_W  = 13;
   localparam int TIME_W    = 32;
   localparam int HEADING_W = 14;
   localparam int UNWRAP_W  = 32;
   localparam int CORR_W    = 13;
   localparam int THRESH_W  = 8;
   localparam int INTERVAL_W = 16;
   localparam int CSR_DATA_W = 16;

   // Turn constants, tenths of a degree
   localparam int CORR_LIMIT = 3600;
   localparam int FULL_TURN  = 3600;
   localparam int HALF_TURN  = 1800;

   // Reset values of the registers
   localparam logic [THRESH_W-1:0]   THRESH_RESET   = 8'd3;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd250;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_DRIFT_THRESHOLD = 1'b0,
      CSR_CHECK_INTERVAL  = 1'b1
   } csr_index_type;

endpackage

/* rtl/gyro_heading_drift_unwrap.sv */
// ----------------------------------------------------------------------------
// Gyro heading drift unwrap
// Absorbs motionless gyro drift into a correction, forms the corrected
// heading and accumulates a saturating unwrapped heading.
// ----------------------------------------------------------------------------
//
// Usage:
//   The req_ channel carries one gyro item (gyro_sample in tenths of a
//   degree, now_ms timestamp). Each item yields exactly one rsp_ item with
//   the corrected heading, the unwrapped heading and the drift correction.
//   The csr_ port writes drift_threshold (index 0) and check_interval_ms
//   (index 1); write only while no item is in flight.
//   Path: an accepted item waits in the input register, passes through the
//   update logic and is then held in the result register, which drives
//   rsp_ until the receiver takes it.
//   Throughput: one item per cycle while rsp_ready stays high. The update
//   logic reads and writes the heading state in the same cycle, so each
//   item sees the state left by the previous one without a bubble.
//   Stall: while rsp_ready is low the result register holds; the input
//   register still takes one more item, then req_ready drops.
//   Reset: synchronous; empties both registers, clears all heading state
//   and loads the register reset values (threshold 3, interval 250 ms).
//
module gyro_heading_drift_unwrap
   import gyro_hdu_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_W-1:0]    req_gyro_sample,
   input  logic        [TIME_W-1:0]      req_now_ms,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [HEADING_W-1:0]   rsp_heading_tenths,
   output logic signed [UNWRAP_W-1:0]    rsp_unwrapped_tenths,
   output logic signed [CORR_W-1:0]      rsp_drift_correction,
   // configuration writes
   input  logic                          csr_we,
   input  logic        [0:0]             csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_wdata
);

   // Registers
   logic                          in_valid_ff;
   logic signed [SAMPLE_W-1:0]    in_sample_ff;
   logic        [TIME_W-1:0]      in_now_ff;
   logic                          out_valid_ff;
   logic signed [HEADING_W-1:0]   out_heading_ff;
   logic signed [UNWRAP_W-1:0]    out_unwrap_ff;
   logic signed [CORR_W-1:0]      out_corr_ff;
   logic        [THRESH_W-1:0]    thresh_ff;
   logic        [INTERVAL_W-1:0]  interval_ff;
   logic signed [SAMPLE_W-1:0]    check_sample_ff;
   logic        [TIME_W-1:0]      check_time_ff;
   logic signed [CORR_W-1:0]      corr_ff;
   logic signed [HEADING_W-1:0]   prev_heading_ff;
   logic signed [UNWRAP_W-1:0]    cont_ff;

   // Next values
   logic signed [CORR_W-1:0]      corr_in;
   logic signed [HEADING_W-1:0]   heading_in;
   logic signed [UNWRAP_W-1:0]    cont_in;
   logic                          check_in;

   logic advance;
   logic req_fire;

   // Move the item from input register to result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Update logic for one item
   always_comb begin
      logic [TIME_W-1:0]      elapsed;
      logic signed [13:0]     diff;
      logic signed [13:0]     diff_abs;
      logic signed [14:0]     corr_sum;
      logic signed [13:0]     head_sum;
      logic signed [14:0]     delta;
      logic signed [15:0]     delta_fold;
      logic signed [32:0]     cont_sum;

      elapsed  = in_now_ff - check_time_ff;
      check_in = elapsed > TIME_W'(interval_ff);

      // drift check against the last check sample
      diff     = 14'(in_sample_ff) - 14'(check_sample_ff);
      diff_abs = diff[13] ? -diff : diff;
      corr_sum = 15'(corr_ff) - 15'(diff);
      corr_in  = corr_ff;
      if (check_in && ($unsigned(diff_abs) < 14'(thresh_ff))) begin
         if (corr_sum > 15'(CORR_LIMIT)) begin
            corr_in = CORR_W'(CORR_LIMIT);
         end else if (corr_sum < -15'(CORR_LIMIT)) begin
            corr_in = -CORR_W'(CORR_LIMIT);
         end else begin
            corr_in = corr_sum[CORR_W-1:0];
         end
      end

      // corrected heading, lifted once when negative
      head_sum = 14'(in_sample_ff) + 14'(corr_in);
      if (head_sum[13]) begin
         heading_in = head_sum + 14'(FULL_TURN);
      end else begin
         heading_in = head_sum;
      end

      // fold the change toward a half turn and accumulate with saturation
      delta = 15'(heading_in) - 15'(prev_heading_ff);
      if (delta > 15'(HALF_TURN)) begin
         delta_fold = 16'(delta) - 16'(FULL_TURN);
      end else if (delta < -15'(HALF_TURN)) begin
         delta_fold = 16'(delta) + 16'(FULL_TURN);
      end else begin
         delta_fold = 16'(delta);
      end
      cont_sum = 33'(cont_ff) + 33'(delta_fold);
      if (cont_sum[32] != cont_sum[31]) begin
         cont_in = cont_sum[32] ? {1'b1, {(UNWRAP_W-1){1'b0}}}
                                : {1'b0, {(UNWRAP_W-1){1'b1}}};
      end else begin
         cont_in = cont_sum[UNWRAP_W-1:0];
      end
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         thresh_ff       <= THRESH_RESET;
         interval_ff     <= INTERVAL_RESET;
         check_sample_ff <= '0;
         check_time_ff   <= '0;
         corr_ff         <= '0;
         prev_heading_ff <= '0;
         cont_ff         <= '0;
      end else begin
         // hold or load the input register
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         // hold or load the result register
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         // advance heading state
         if (advance) begin
            corr_ff         <= corr_in;
            prev_heading_ff <= heading_in;
            cont_ff         <= cont_in;
            if (check_in) begin
               check_sample_ff <= in_sample_ff;
               check_time_ff   <= in_now_ff;
            end
         end
         // configuration writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DRIFT_THRESHOLD: thresh_ff   <= csr_wdata[THRESH_W-1:0];
               CSR_CHECK_INTERVAL:  interval_ff <= csr_wdata[INTERVAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_gyro_sample;
         in_now_ff    <= req_now_ms;
      end
      if (advance) begin
         out_heading_ff <= heading_in;
         out_unwrap_ff  <= cont_in;
         out_corr_ff    <= corr_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_heading_tenths   = out_heading_ff;
   assign rsp_unwrapped_tenths = out_unwrap_ff;
   assign rsp_drift_correction = out_corr_ff;

`ifndef SYNTHESIS
   // Correction never leaves its saturation range
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      (corr_ff <= CORR_W'(CORR_LIMIT)) && (corr_ff >= -CORR_W'(CORR_LIMIT)))
      else $error("drift correction out of range");

   // Shown result matches the state it left behind
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unwrapped_tenths == cont_ff) &&
                    (rsp_drift_correction == corr_ff) &&
                    (rsp_heading_tenths == prev_heading_ff))
      else $error("result register and heading state disagree");

   // Both registers full and a stalled receiver block new items
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted while both registers are full");

   // Check point moves only when an item advances
   a_check_move: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && ($past(check_time_ff) != check_time_ff) |-> $past(advance))
      else $error("check time changed without an item");
`endif

endmodule

/* test/gyro_heading_drift_unwrap_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gyro heading drift unwrap testbench
// Drives gyro items through the req_ handshake and predicts each result in
// a scoreboard. The scoreboard keeps its own drift check point, correction,
// last heading and unwrapped heading. The stimulus starts with a short
// directed part. Random phases follow under several register settings and
// idle patterns. One phase climbs the unwrapped heading by about half a
// turn per item.
// ----------------------------------------------------------------------------
module gyro_heading_drift_unwrap_tb;
   import gyro_hdu_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SAMPLE_MIN  = -4096;
   localparam int SAMPLE_MAX  = 4095;
   localparam logic signed [UNWRAP_W-1:0] UNWRAP_MAX = {1'b0, {(UNWRAP_W-1){1'b1}}};
   localparam logic signed [UNWRAP_W-1:0] UNWRAP_MIN = {1'b1, {(UNWRAP_W-1){1'b0}}};

   typedef struct {
      logic signed [HEADING_W-1:0] heading;
      logic signed [UNWRAP_W-1:0]  unwrapped;
      logic signed [CORR_W-1:0]    correction;
   } heading_result_type;

   // Heading predictor and store of expected results
   class heading_scoreboard;
      logic [THRESH_W-1:0]         threshold;
      logic [INTERVAL_W-1:0]       interval;
      logic signed [SAMPLE_W-1:0]  check_sample;
      logic [TIME_W-1:0]           check_time;
      logic signed [CORR_W-1:0]    correction;
      logic signed [HEADING_W-1:0] last_heading;
      logic signed [UNWRAP_W-1:0]  unwrapped;
      heading_result_type          pending_q[$];
      int                          mismatches;

      function new();
         threshold    = THRESH_RESET;
         interval     = INTERVAL_RESET;
         check_sample = '0;
         check_time   = '0;
         correction   = '0;
         last_heading = '0;
         unwrapped    = '0;
         mismatches   = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%s", msg);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DRIFT_THRESHOLD: threshold = data[THRESH_W-1:0];
            CSR_CHECK_INTERVAL:  interval  = data[INTERVAL_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the heading state by one accepted item and queue its result
      function void note_item(logic signed [SAMPLE_W-1:0] gyro, logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0]  elapsed;
         int                 diff, mag, corr, head, delta;
         longint             acc;
         heading_result_type res;
         elapsed = stamp - check_time;
         // drift check: absorb small changes since the last check point
         if (elapsed > interval) begin
            diff = int'(gyro) - int'(check_sample);
            mag  = (diff < 0) ? -diff : diff;
            if (mag < int'(threshold)) begin
               corr = int'(correction) - diff;
               if (corr > CORR_LIMIT)
                  corr = CORR_LIMIT;
               if (corr < -CORR_LIMIT)
                  corr = -CORR_LIMIT;
               correction = CORR_W'(corr);
            end
            check_sample = gyro;
            check_time   = stamp;
         end
         head = int'(gyro) + int'(correction);
         if (head < 0)
            head += FULL_TURN;
         // fold the change once toward half a turn
         delta = head - int'(last_heading);
         if (delta > HALF_TURN)
            delta -= FULL_TURN;
         if (delta < -HALF_TURN)
            delta += FULL_TURN;
         last_heading = HEADING_W'(head);
         acc = longint'(unwrapped) + delta;
         if (acc > longint'(UNWRAP_MAX))
            acc = longint'(UNWRAP_MAX);
         if (acc < longint'(UNWRAP_MIN))
            acc = longint'(UNWRAP_MIN);
         unwrapped = UNWRAP_W'(acc);
         res.heading    = last_heading;
         res.unwrapped  = unwrapped;
         res.correction = correction;
         pending_q.push_back(res);
      endfunction

      // Compare one result with the oldest expected one
      function void check_result(logic signed [HEADING_W-1:0] heading,
                                 logic signed [UNWRAP_W-1:0] unwrap,
                                 logic signed [CORR_W-1:0] corr);
         heading_result_type want;
         if (pending_q.size() == 0) begin
            flag($sformatf("unexpected result: heading %0d unwrapped %0d correction %0d",
                           heading, unwrap, corr));
            return;
         end
         want = pending_q.pop_front();
         if (heading !== want.heading)
            flag($sformatf("heading_tenths: expected %0d, got %0d", want.heading, heading));
         if (unwrap !== want.unwrapped)
            flag($sformatf("unwrapped_tenths: expected %0d, got %0d", want.unwrapped, unwrap));
         if (corr !== want.correction)
            flag($sformatf("drift_correction: expected %0d, got %0d", want.correction, corr));
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_gyro_sample;
   logic [TIME_W-1:0]            req_now_ms;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [HEADING_W-1:0]  rsp_heading_tenths;
   logic signed [UNWRAP_W-1:0]   rsp_unwrapped_tenths;
   logic signed [CORR_W-1:0]     rsp_drift_correction;
   logic                         csr_we;
   logic [0:0]                   csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   heading_scoreboard heading_sb;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                hold_cycles;
   int                quiet_cycles;
   int                walk_sample;
   logic [TIME_W-1:0] walk_time;

   gyro_heading_drift_unwrap i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_gyro_sample      (req_gyro_sample),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_heading_tenths   (rsp_heading_tenths),
      .rsp_unwrapped_tenths (rsp_unwrapped_tenths),
      .rsp_drift_correction (rsp_drift_correction),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check each result, then draw the next ready (or hold it off)
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         heading_sb.check_result(rsp_heading_tenths, rsp_unwrapped_tenths,
                                 rsp_drift_correction);
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, hold it until accepted, then predict its result
   task automatic send_item(input logic signed [SAMPLE_W-1:0] gyro,
                            input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_gyro_sample <= gyro;
      req_now_ms      <= stamp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      heading_sb.note_item(gyro, stamp);
   endtask

   // Stop offering and wait until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (heading_sb.pending_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers while the block is idle; junk in the unused threshold bits
   task automatic configure(input int thr, input int interval);
      logic [CSR_DATA_W-1:0] word;
      drain();
      word                 = CSR_DATA_W'($urandom);
      word[THRESH_W-1:0]   = THRESH_W'(thr);
      csr_we    <= 1'b1;
      csr_index <= CSR_DRIFT_THRESHOLD;
      csr_wdata <= word;
      @(posedge clock);
      heading_sb.write_reg(CSR_DRIFT_THRESHOLD, word);
      csr_index <= CSR_CHECK_INTERVAL;
      csr_wdata <= CSR_DATA_W'(interval);
      @(posedge clock);
      heading_sb.write_reg(CSR_CHECK_INTERVAL, CSR_DATA_W'(interval));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Time edges, field extremes, threshold edges and both rollover folds
   task automatic directed_items();
      send_item(0, 0);
      send_item(2, 250);
      send_item(2, 251);
      send_item(-1, 600);
      send_item(-3, 900);
      send_item(3600, 901);
      send_item(-3600, 902);
      send_item(4095, 903);
      send_item(-4096, 904);
      send_item(1000, 32'hFFFF_FFF0);
      send_item(1001, 32'h0000_0100);
      send_item(3000, 32'h0000_0101);
      send_item(100, 32'h0000_0102);
      send_item(-2000, 32'hFFFF_FFFF);
      send_item(1, 0);
      // zero threshold and zero interval
      configure(0, 0);
      send_item(1, 1);
      send_item(2, 2);
      send_item(2, 2);
      send_item(3, 3);
      // widest threshold and interval
      configure(255, 65535);
      send_item(10, 65538);
      send_item(10, 65538);
      send_item(11, 65539);
      walk_sample = 11;
      walk_time   = 65539;
   endtask

   // Mostly drifting walks around the check interval, some jumps and noise
   task automatic random_items(input int count, input int dir);
      int                pick, step, thr, interval, gyro, n;
      logic [TIME_W-1:0] stamp;
      thr      = heading_sb.threshold;
      interval = heading_sb.interval;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            step = (thr == 0) ? $urandom_range(3) : $urandom_range(thr - 1);
            if ($urandom_range(9) == 0)
               step = thr + $urandom_range(2);
            if (dir == 0)
               gyro = walk_sample + ($urandom_range(1) ? step : -step);
            else
               gyro = walk_sample + dir * step;
            if (gyro > SAMPLE_MAX || gyro < SAMPLE_MIN)
               gyro = $urandom_range(7200) - 3600;
            case ($urandom_range(3))
               0:       stamp = walk_time + interval;
               1:       stamp = walk_time + interval + 1;
               default: stamp = walk_time + $urandom_range(2 * interval + 2);
            endcase
         end else if (pick < 90) begin
            gyro  = $urandom_range(7200) - 3600;
            stamp = walk_time + $urandom_range(2 * interval + 2);
         end else begin
            gyro  = $urandom_range(8191) - 4096;
            stamp = $urandom;
         end
         walk_sample = gyro;
         walk_time   = stamp;
         send_item(SAMPLE_W'(gyro), stamp);
      end
   endtask

   // Step the heading by +1800 / -1801 so every change adds about half a
   // turn; the correction stays fixed since the threshold is zero
   task automatic climb_heading(input int count);
      int target, gyro, n;
      target = 0;
      for (n = 0; n < count; n++) begin
         if (target < HALF_TURN)
            target += HALF_TURN;
         else if (target == HALF_TURN)
            target = FULL_TURN - 1;
         else
            target -= HALF_TURN + 1;
         gyro = target - int'(heading_sb.correction);
         if (gyro > SAMPLE_MAX)
            gyro -= FULL_TURN;
         send_item(SAMPLE_W'(gyro), walk_time);
      end
   endtask

   initial begin
      heading_sb      = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_gyro_sample = '0;
      req_now_ms      = '0;
      rsp_ready       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_DRIFT_THRESHOLD;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_cycles     = 0;
      quiet_cycles    = 0;
      walk_sample     = 0;
      walk_time       = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_items();

      // drift walks upward: correction heads for its negative limit
      configure(255, 0);
      random_items(300, 1);

      send_idle_pct = 87;
      configure(255, 65535);
      random_items(300, -1);

      // long receiver hold while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 87;
      configure(0, 0);
      hold_cycles = 400;
      random_items(300, 0);

      send_idle_pct  = 19;
      recv_stall_pct = 19;
      configure(THRESH_RESET, INTERVAL_RESET);
      random_items(300, 0);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure($urandom_range(255), $urandom_range(1000));
      random_items(300, 0);

      recv_stall_pct = 87;
      configure(1, 65535);
      random_items(200, 0);

      // climb the unwrapped heading by about half a turn per item
      recv_stall_pct = 0;
      configure(0, 250);
      climb_heading(100);

      send_idle_pct  = 19;
      recv_stall_pct = 19;
      configure(128, 20);
      random_items(200, -1);

      recv_stall_pct = 0;
      drain();
      repeat (8) @(posedge clock);
      if (heading_sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
rtl/gyro_hdu_pkg.sv
rtl/gyro_heading_drift_unwrap.sv
test/gyro_heading_drift_unwrap_tb.sv
